>>> design/md5_message_digest_assert.svh
// Assertion macros for the MD5 digest block
`ifndef MD5_MESSAGE_DIGEST_ASSERT_SVH
`define MD5_MESSAGE_DIGEST_ASSERT_SVH
// Implication checked on every rising clock edge outside reset
`define MD5_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset
`define MD5_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> design/md5_pkg.sv
// ---------------------------------------------------------------------------
// md5_pkg
// Constants, types and round functions shared by the MD5 digest modules.
// ---------------------------------------------------------------------------
package md5_pkg;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam int          BLOCK_BYTES = 64;
  localparam int          LEN_POS = 56;

  // Byte source selected for a buffer write
  localparam logic [1:0] WSEL_DATA = 2'd0;
  localparam logic [1:0] WSEL_PAD  = 2'd1;
  localparam logic [1:0] WSEL_ZERO = 2'd2;
  localparam logic [1:0] WSEL_LEN  = 2'd3;

  // Commands from controller to datapath
  typedef struct packed {
    logic       buf_we;
    logic [1:0] wsel;
    logic       len_add;
    logic       rnd_start;
    logic       rnd_step;
    logic       chain_add;
    logic       chain_init;
    logic       out_load;
  } md5_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [5:0] round;
  } md5_sts_t;

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    unique case (r)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] round_s(input logic [5:0] r);
    logic [4:0] s;
    unique case ({r[5:4], r[1:0]})
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

  // Message word index used in a given round
  function automatic logic [3:0] round_w(input logic [5:0] r);
    logic [3:0] i;
    unique case (r[5:4])
      2'd0: i = r[3:0];
      2'd1: i = 4'(5 * r[3:0] + 1);
      2'd2: i = 4'(3 * r[3:0] + 5);
      default: i = 4'(7 * r[3:0]);
    endcase
    return i;
  endfunction

endpackage

>>> design/md5_ctrl.sv
// ---------------------------------------------------------------------------
// md5_ctrl
// Sequencer: byte collection, padding, 64-round compression and output.
// ---------------------------------------------------------------------------
module md5_ctrl import md5_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_byte_valid,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [5:0] widx,
  output md5_cmd_t   cmd,
  input  md5_sts_t   sts
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_RND  = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [5:0] fill_r, fill_nxt;
  logic       fin_r, fin_nxt;     // padding pending after this block
  logic       lenb_r, lenb_nxt;   // current block carries the length
  logic       padg_r, padg_nxt;   // padding of the message under way
  logic       ov_r, ov_nxt;
  logic       acc;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ov_r;
  assign acc       = in_valid && in_ready;
  assign widx      = fill_r;

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    fin_nxt   = fin_r;
    lenb_nxt  = lenb_r;
    padg_nxt  = padg_r;
    ov_nxt    = ov_r;
    cmd       = '0;
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (in_byte_valid) begin
            cmd.buf_we  = 1'b1;
            cmd.wsel    = WSEL_DATA;
            cmd.len_add = 1'b1;
            fill_nxt    = fill_r + 6'd1;
          end
          fin_nxt = in_last;
          if (in_byte_valid && fill_r == 6'd63) begin
            cmd.rnd_start = 1'b1;
            state_nxt     = S_RND;
          end else if (in_last) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        // Write pad byte, zeros, then length bytes
        cmd.buf_we = 1'b1;
        fill_nxt   = fill_r + 6'd1;
        if (fin_r) begin
          cmd.wsel = WSEL_PAD;
          fin_nxt  = 1'b0;
          padg_nxt = 1'b1;
          lenb_nxt = (fill_r < 6'(LEN_POS));
        end else if (lenb_r && fill_r >= 6'(LEN_POS)) begin
          cmd.wsel = WSEL_LEN;
        end else begin
          cmd.wsel = WSEL_ZERO;
        end
        if (fill_r == 6'd63) begin
          cmd.rnd_start = 1'b1;
          state_nxt     = S_RND;
        end
      end
      S_RND: begin
        cmd.rnd_step = 1'b1;
        if (sts.round == 6'd63) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // Fold the block in, then collect, pad further or emit
        cmd.chain_add = 1'b1;
        if (fin_r) begin
          state_nxt = S_PAD;
        end else if (!padg_r) begin
          state_nxt = S_IDLE;
        end else if (!lenb_r) begin
          lenb_nxt  = 1'b1;
          state_nxt = S_PAD;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov_r) begin
          cmd.out_load   = 1'b1;
          cmd.chain_init = 1'b1;
          ov_nxt         = 1'b1;
          lenb_nxt       = 1'b0;
          padg_nxt       = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      fin_r   <= 1'b0;
      lenb_r  <= 1'b0;
      padg_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      fin_r   <= fin_nxt;
      lenb_r  <= lenb_nxt;
      padg_r  <= padg_nxt;
      ov_r    <= ov_nxt;
    end
  end

endmodule

>>> design/md5_dp.sv
// ---------------------------------------------------------------------------
// md5_dp
// Datapath: block buffer, bit length, round unit and chaining value.
// ---------------------------------------------------------------------------
module md5_dp import md5_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_byte_value,
  input  logic [5:0]  widx,
  input  md5_cmd_t    cmd,
  output md5_sts_t    sts,
  output logic [63:0] out_digest_low,
  output logic [63:0] out_digest_high
);

  logic [31:0]  buf_r [BLOCK_BYTES / 4];
  logic [63:0]  len_r;
  logic [31:0]  ch_r [4];
  logic [31:0]  a_r, b_r, c_r, d_r;
  logic [5:0]   rnd_r;
  logic [63:0]  dl_r, dh_r;
  logic [7:0]   wbyte;
  logic [31:0]  f, w, sum;
  logic [4:0]   sh;
  logic [3:0]   wi;
  logic [2:0]   lsel;

  assign lsel = widx[2:0];
  always_comb begin
    unique case (cmd.wsel)
      WSEL_DATA: wbyte = in_byte_value;
      WSEL_PAD:  wbyte = PAD_BYTE;
      WSEL_ZERO: wbyte = 8'h00;
      default:   wbyte = len_r[{lsel, 3'b000} +: 8];
    endcase
  end

  // Store bytes into the word-wide block buffer, little-endian within a word
  always_ff @(posedge clk) begin
    if (cmd.buf_we) begin
      buf_r[widx[5:2]][{widx[1:0], 3'b000} +: 8] <= wbyte;
    end
  end

  // Round function for the current round
  assign wi = round_w(rnd_r);
  assign w  = buf_r[wi];
  assign sh = round_s(rnd_r);
  always_comb begin
    unique case (rnd_r[5:4])
      2'd0: f = (b_r & c_r) | (~b_r & d_r);
      2'd1: f = (d_r & b_r) | (~d_r & c_r);
      2'd2: f = b_r ^ c_r ^ d_r;
      default: f = c_r ^ (b_r | ~d_r);
    endcase
  end
  assign sum = a_r + f + round_k(rnd_r) + w;
  assign sts.round = rnd_r;

  // Start and advance rounds, fold into the chain, reinitialise chain and length
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      ch_r  <= '{INIT_A, INIT_B, INIT_C, INIT_D};
      rnd_r <= '0;
    end else begin
      if (cmd.len_add) len_r <= len_r + 64'd8;
      if (cmd.rnd_start) begin
        a_r <= ch_r[0]; b_r <= ch_r[1]; c_r <= ch_r[2]; d_r <= ch_r[3];
        rnd_r <= '0;
      end
      if (cmd.rnd_step) begin
        a_r   <= d_r;
        d_r   <= c_r;
        c_r   <= b_r;
        b_r   <= b_r + ((sum << sh) | (sum >> (6'd32 - {1'b0, sh})));
        rnd_r <= rnd_r + 6'd1;
      end
      if (cmd.chain_add) begin
        ch_r[0] <= ch_r[0] + a_r; ch_r[1] <= ch_r[1] + b_r;
        ch_r[2] <= ch_r[2] + c_r; ch_r[3] <= ch_r[3] + d_r;
      end
      if (cmd.chain_init) begin
        ch_r  <= '{INIT_A, INIT_B, INIT_C, INIT_D};
        len_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      dl_r <= {ch_r[1], ch_r[0]};
      dh_r <= {ch_r[3], ch_r[2]};
    end
  end

  assign out_digest_low  = dl_r;
  assign out_digest_high = dh_r;

endmodule

>>> design/md5_message_digest.sv
// ---------------------------------------------------------------------------
// md5_message_digest
// MD5 digest of a byte stream, at most one byte per item, 128-bit result per message.
// ---------------------------------------------------------------------------
//  channel | ports                                   | moves
//  in      | in_valid/in_ready, byte_value/valid/last | one byte or end mark
//  out     | out_valid/out_ready, digest_low/high     | one digest
//
// Bytes are taken only while idle; the 64th byte of a block starts the 64
// rounds, then the chain update, and only after that is the next item taken.
// On last, padding writes one buffer byte a cycle up to the block end and
// one or two blocks run; the digest register then loads once any waiting digest is taken.
// Input goes on while a digest waits; only the next digest stalls for it.
// Reset clears control, chain value and length; the buffer needs none.
module md5_message_digest import md5_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_value,
  input  logic        in_byte_valid,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_digest_low,
  output logic [63:0] out_digest_high
);

  md5_cmd_t   cmd;
  md5_sts_t   sts;
  logic [5:0] widx;

  md5_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_byte_valid, .in_last,
    .out_valid, .out_ready, .widx, .cmd, .sts
  );

  md5_dp u_dp (
    .clk, .rst_n, .in_byte_value, .widx, .cmd, .sts,
    .out_digest_low, .out_digest_high
  );

endmodule

>>> design/md5_checker.sv
// ---------------------------------------------------------------------------
// md5_checker
// Port-level checks on the MD5 digest block.
// ---------------------------------------------------------------------------
`include "md5_message_digest_assert.svh"
module md5_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_digest_low,
  input logic [63:0] out_digest_high
);
  `MD5_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_digest_low), "digest dropped")
  `MD5_ASSERT_NXT(a_out_hold_high, clk, rst_n, out_valid && !out_ready, $stable(out_digest_high), "digest changed while waiting")
  `MD5_ASSERT_NXT(a_last_busy, clk, rst_n, in_valid && in_ready && in_last, !in_ready, "no padding after last")
endmodule

bind md5_message_digest md5_checker u_chk (
  .clk, .rst_n, .in_valid, .in_ready, .in_last, .out_valid, .out_ready, .out_digest_low,
  .out_digest_high
);

>>> bench/md5_message_digest_tb.sv
// ---------------------------------------------------------------------------
// md5_message_digest_tb
// Byte-stream MD5 digest bench: directed and random messages are streamed in,
// each digest is predicted in the bench and compared field by field.
// ---------------------------------------------------------------------------
module md5_message_digest_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SHOWN = 10;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte_value;
  logic        in_byte_valid;
  logic        in_last;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_digest_low;
  logic [63:0] out_digest_high;

  md5_message_digest dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_byte_value(in_byte_value), .in_byte_valid(in_byte_valid), .in_last(in_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_digest_low(out_digest_low), .out_digest_high(out_digest_high)
  );

  // Predictor state
  logic [31:0] hash_state [4];
  logic [7:0]  msg_block [64];
  int          block_fill;
  logic [63:0] msg_bits;

  logic [127:0] digest_queue [$];
  int  mismatches;
  int  digests_seen;
  int  items_sent;
  bit  sender_idles;
  bit  receiver_idles;
  bit  hold_off;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
    return (n == 0) ? v : ((v << n) | (v >> (32 - n)));
  endfunction

  // Compress the gathered block into the chaining value
  task automatic compress_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, f, t;
    int idx;
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i+3], msg_block[4*i+2], msg_block[4*i+1], msg_block[4*i]};
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        f = (b & c) | (~b & d); idx = r;
      end else if (r < 32) begin
        f = (d & b) | (~d & c); idx = (5*r + 1) % 16;
      end else if (r < 48) begin
        f = b ^ c ^ d; idx = (3*r + 5) % 16;
      end else begin
        f = c ^ (b | ~d); idx = (7*r) % 16;
      end
      t = d; d = c; c = b;
      b = b + rotl(a + f + md5_pkg::round_k(6'(r)) + w[idx], md5_pkg::round_s(6'(r)));
      a = t;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
  endtask

  task automatic restart_digest();
    hash_state[0] = md5_pkg::INIT_A; hash_state[1] = md5_pkg::INIT_B;
    hash_state[2] = md5_pkg::INIT_C; hash_state[3] = md5_pkg::INIT_D;
    block_fill = 0;
    msg_bits = '0;
  endtask

  // Advance the predicted digest by one accepted item
  task automatic predict_digest(input logic [7:0] bv, input logic vld, input logic lst);
    if (vld) begin
      msg_block[block_fill] = bv;
      block_fill++;
      msg_bits += 64'd8;
      if (block_fill == 64) begin
        compress_block();
        block_fill = 0;
      end
    end
    if (lst) begin
      msg_block[block_fill] = md5_pkg::PAD_BYTE;
      block_fill++;
      if (block_fill > md5_pkg::LEN_POS) begin
        while (block_fill < 64) msg_block[block_fill++] = 8'h00;
        compress_block();
        block_fill = 0;
      end
      while (block_fill < md5_pkg::LEN_POS) msg_block[block_fill++] = 8'h00;
      for (int k = 0; k < 8; k++) msg_block[56+k] = msg_bits[8*k +: 8];
      compress_block();
      digest_queue.push_back({hash_state[3], hash_state[2], hash_state[1], hash_state[0]});
      restart_digest();
    end
  endtask

  // Send one item and hold it until accepted; drop valid only while idling
  task automatic send_item(input logic [7:0] bv, input logic vld, input logic lst);
    while (sender_idles && ($urandom_range(0, 99) < 27)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte_value <= bv;
    in_byte_valid <= vld;
    in_last <= lst;
    do @(posedge clk); while (!in_ready);
    predict_digest(bv, vld, lst);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++)
      send_item(8'($urandom), 1'b1, (i == len - 1) && $urandom_range(0, 1));
    if (in_last !== 1'b1 || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (digest_queue.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  // Check each accepted digest against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      logic [127:0] want;
      if (digest_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) $display("digest with none predicted: %h %h",
                                              out_digest_high, out_digest_low);
      end else begin
        want = digest_queue.pop_front();
        digests_seen++;
        if (out_digest_low !== want[63:0] || out_digest_high !== want[127:64]) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("digest mismatch: expected %h %h got %h %h", want[127:64],
                     want[63:0], out_digest_high, out_digest_low);
        end
      end
    end
  end

  // Drive out_ready with random idling and a long hold-off on request
  always @(negedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else out_ready <= !(receiver_idles && ($urandom_range(0, 99) < 27));
  end

  task automatic test_directed();
    send_item(8'h00, 1'b0, 1'b1);             // empty message
    send_item(8'h00, 1'b0, 1'b0);             // ignored item
    send_item(8'h61, 1'b1, 1'b1);             // byte together with last
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h5a, 1'b0, 1'b1);             // end mark without byte
    wait_drained();
  endtask

  task automatic test_block_edges();
    // lengths around pad boundaries and full blocks
    send_message(55); send_message(56); send_message(63);
    send_message(64); send_message(65);
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin repeat (400) @(negedge clk); hold_off = 1'b0; end
      begin for (int m = 0; m < 4; m++) send_message($urandom_range(0, 10)); end
    join
    wait_drained();
  endtask

  task automatic test_random();
    receiver_idles = 1'b0; sender_idles = 1'b0;
    for (int m = 0; m < 10; m++) send_message($urandom_range(0, 8));
    receiver_idles = 1'b1; sender_idles = 1'b1;
    while (items_sent < 400) begin
      if ($urandom_range(0, 9) == 0)
        send_item(8'($urandom), 1'b0, 1'b0);   // noise
      else
        send_message(($urandom_range(0, 9) == 0) ? $urandom_range(0, 140)
                                                 : $urandom_range(0, 12));
    end
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0; in_valid = 1'b0; in_byte_value = '0; in_byte_valid = 1'b0;
    in_last = 1'b0; out_ready = 1'b0; hold_off = 1'b0;
    sender_idles = 1'b1; receiver_idles = 1'b1;
    mismatches = 0; digests_seen = 0; items_sent = 0;
    for (int i = 0; i < 64; i++) msg_block[i] = '0;
    restart_digest();
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_block_edges();
    test_backpressure();
    test_random();
    $display("Sent %0d items, checked %0d digests incl. empty, pad-edge and", items_sent,
             digests_seen);
    $display("multi-block messages under stalls; mismatches %0d", mismatches);
    if (mismatches == 0 && digest_queue.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // Stop the run if it hangs
  initial begin
    #4ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
